/* design/rfnb_pkg.sv */
// shared types, constants and crc helper for the radio frame nybble builder
package rfnb_pkg;

    localparam int JOB_DEPTH = 6;
    localparam int IDX_W     = $clog2(JOB_DEPTH);
    localparam int CNT_W     = $clog2(JOB_DEPTH + 1);

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [7:0]  COUNT_EXTRA = 8'd3;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_BYTE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_NO_FRAME = 2'd2
    } t_status;

    // results caused by one input item
    typedef struct packed {
        logic [JOB_DEPTH-1:0][3:0] nyb;
        logic [CNT_W-1:0]          cnt;
        t_status                   status;
        logic                      fend;
    } t_job;

    // reflected crc-ccitt, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/rfnb_frame.sv */
// frame state, crc update and per-item result list builder
module rfnb_frame
    import rfnb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 27
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_func      i_func,
    input  logic [7:0] i_value,
    output t_job       o_job
);

    localparam int BL_W = $clog2(MAX_PAYLOAD + 1);

    logic [15:0]     r_crc, n_crc;
    logic [BL_W-1:0] r_bytes_left, n_bytes_left;
    logic            r_open, n_open;

    logic [7:0]  count;
    logic [7:0]  byte_sel;
    logic [15:0] crc_in;
    logic [15:0] crc_new;
    logic [15:0] fcs;

    assign count    = i_value + COUNT_EXTRA;
    assign byte_sel = (i_func == FUNC_START) ? count : i_value;
    assign crc_in   = (i_func == FUNC_START) ? CRC_INIT : r_crc;
    assign crc_new  = crc_feed(crc_in, byte_sel);
    assign fcs      = ~crc_new;

    always_comb begin
        o_job        = '0;
        o_job.status = ST_OK;
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_open       = r_open;
        case (i_func)
            FUNC_START: begin
                if (i_value > 8'(MAX_PAYLOAD)) begin
                    o_job.cnt    = CNT_W'(1);
                    o_job.status = ST_TOO_LONG;
                end else begin
                    n_crc        = crc_new;
                    n_bytes_left = i_value[BL_W-1:0];
                    n_open       = 1'b1;
                end
            end
            FUNC_BYTE: begin
                if (!r_open) begin
                    o_job.cnt    = CNT_W'(1);
                    o_job.status = ST_NO_FRAME;
                end else begin
                    n_crc        = crc_new;
                    n_bytes_left = r_bytes_left - BL_W'(1);
                end
            end
            default: ;
        endcase
        if (o_job.status == ST_OK) begin
            o_job.nyb[0] = byte_sel[7:4];
            o_job.nyb[1] = byte_sel[3:0];
            o_job.cnt    = CNT_W'(2);
            // payload done: append complemented crc, low byte first
            if (n_bytes_left == '0) begin
                o_job.nyb[2] = fcs[7:4];
                o_job.nyb[3] = fcs[3:0];
                o_job.nyb[4] = fcs[15:12];
                o_job.nyb[5] = fcs[11:8];
                o_job.cnt    = CNT_W'(JOB_DEPTH);
                o_job.fend   = 1'b1;
                n_crc        = CRC_INIT;
                n_open       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_bytes_left <= '0;
            r_open       <= 1'b0;
        end else if (i_take) begin
            r_crc        <= n_crc;
            r_bytes_left <= n_bytes_left;
            r_open       <= n_open;
        end
    end

endmodule

/* design/rfnb_serial.sv */
// result list register and output register that sends one nybble per cycle while m_axis_tready is high
module rfnb_serial
    import rfnb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_job_ready,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output logic       m_axis_tuser
);

    t_job             r_job;
    logic             r_job_valid;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [3:0]       r_out_nyb;
    t_status          r_out_status;
    logic             r_out_last;
    logic             r_out_fend;

    logic move;
    logic at_end;
    logic take_job;

    assign move        = r_job_valid && (!r_out_valid || m_axis_tready);
    assign at_end      = (CNT_W'(r_idx) == r_job.cnt - CNT_W'(1));
    assign o_job_ready = !r_job_valid || (move && at_end);
    assign take_job    = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
        end else if (take_job) begin
            r_job_valid <= 1'b1;
            r_idx       <= '0;
        end else if (move) begin
            if (at_end) begin
                r_job_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_nyb    <= r_job.nyb[r_idx];
            r_out_status <= r_job.status;
            r_out_last   <= at_end;
            r_out_fend   <= at_end && r_job.fend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_status, r_out_nyb};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_fend;

endmodule

/* design/radio_frame_nibble_builder_top.sv */
// top level of the radio frame nybble builder
//
// input channel (s_axis): one transaction per item; tuser selects the item
// kind (0 start a frame with the payload length in tdata, 1 payload byte).
// output channel (m_axis): one transaction per nybble; tdata carries the
// nybble and a status code, tlast marks the final nybble caused by one input
// item, tuser marks the final crc nybble of a frame.
// a start emits the count byte (length plus 3) as two nybbles; each payload
// byte emits two nybbles, high first; after the last byte the complemented
// crc follows as four more nybbles. a rejected item yields a single nybble
// with a nonzero status.
// throughput: one nybble per cycle while m_axis_tready stays high; the
// output register sets that pace. an input register, a result list
// register and the output register are chained, so the next item is
// taken while earlier nybbles still drain. reset clears all valid flags
// and the frame state (crc back to all ones, no frame open). a stall on
// m_axis holds the output and backs up through the stages until
// s_axis_tready drops.
module radio_frame_nibble_builder_top
    import rfnb_pkg::*;
#(
    parameter int MAX_PAYLOAD = 27
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] value
    input  logic       s_axis_tuser,   // [0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] nybble, [5:4] status, [7:6] zero
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] frame_end
);

    // input register
    logic       r_in_valid;
    t_func      r_in_func;
    logic [7:0] r_in_value;

    logic job_ready;
    logic take;
    t_job job;

    assign take          = r_in_valid && job_ready;
    assign s_axis_tready = !r_in_valid || job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func  <= t_func'(s_axis_tuser);
            r_in_value <= s_axis_tdata;
        end
    end

    // frame state and crc; builds the nybble list for one item
    rfnb_frame #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_func  (r_in_func),
        .i_value (r_in_value),
        .o_job   (job)
    );

    // drains the list one nybble per cycle while m_axis_tready is high
    rfnb_serial u_serial (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (r_in_valid),
        .i_job         (job),
        .o_job_ready   (job_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // frame end only on the closing nybble of an item
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without last");

    // a rejected item is a single nybble
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[5:4] != ST_OK) |-> m_axis_tlast && !m_axis_tuser)
        else $error("error result not single");

    // a held input item is not dropped before it moves on
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !job_ready |=> r_in_valid)
        else $error("input item lost");

    // output empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
